FILE: design/paged_memory_manager_defines.svh
// assertion helpers for the paged memory manager
`ifndef PAGED_MEMORY_MANAGER_DEFINES_SVH
`define PAGED_MEMORY_MANAGER_DEFINES_SVH

// implication checked on every rising edge outside reset
`define PMM_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pmm implication violated");

// condition that holds on every rising edge outside reset
`define PMM_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("pmm invariant violated");

`endif

FILE: design/pmm_pkg.sv
`timescale 1ns / 1ps
package pmm_pkg;
	localparam int DEF_ADDR_BITS   = 20;
	localparam int DEF_OFFSET_BITS = 10;
	localparam int DEF_FRAME_COUNT = 1024;
	localparam int DEF_PROC_SLOTS  = 8;

	typedef enum logic [1:0] {
		KIND_ALLOC = 2'd0,
		KIND_FREE  = 2'd1,
		KIND_READ  = 2'd2,
		KIND_WRITE = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_A_CHK,
		ST_A_SCAN,
		ST_A_END,
		ST_F_LOOK,
		ST_F_WALK,
		ST_RW_LOOK,
		ST_RW_DATA,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  pid;
		logic [19:0] vaddr;
		logic [20:0] req_size;
		logic [7:0]  write_data;
	} req_t;

	typedef struct packed {
		logic        status;
		logic [19:0] region_base;
		logic [7:0]  read_data;
	} rsp_t;
endpackage

FILE: design/pmm_ram.sv
`timescale 1ns / 1ps
module pmm_ram #(
	parameter int WIDTH  = 8,
	parameter int ADDR_W = 10
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);
	logic [WIDTH-1:0] mem_q [2**ADDR_W];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

FILE: design/paged_memory_manager.sv
`timescale 1ns / 1ps
// channel | direction | handshake             | payload
// req     | in        | req_valid / req_stall | req_t  (kind, pid, vaddr, req_size, write_data)
// rsp     | out       | rsp_valid / rsp_stall | rsp_t  (status, region_base, read_data)
//
// one request is worked at a time; free walks the released chain frame by frame,
// allocate scans the frame table frame by frame until enough free frames are
// found, and a failed or empty allocate skips the scan; both are paced by the
// single read port of the frame table.
// after reset a clearing pass over the widest address range zeroes byte, frame
// and page memories; req_stall stays high meanwhile.
// a finished result waits in the output register; the next beat is taken meanwhile.
`include "paged_memory_manager_defines.svh"
module paged_memory_manager
	import pmm_pkg::*;
#(
	parameter int ADDR_BITS   = DEF_ADDR_BITS,
	parameter int OFFSET_BITS = DEF_OFFSET_BITS,
	parameter int FRAME_COUNT = DEF_FRAME_COUNT,
	parameter int PROC_SLOTS  = DEF_PROC_SLOTS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);
	localparam int AW      = ADDR_BITS;
	localparam int OFF     = OFFSET_BITS;
	localparam int VPN_W   = AW - OFF;
	localparam int FB      = $clog2(FRAME_COUNT);
	localparam int NEXT_W  = FB + 1;
	localparam int FM_W    = 4 + NEXT_W;
	localparam int PM_W    = 1 + FB;
	localparam int SLOT_W  = (PROC_SLOTS > 1) ? $clog2(PROC_SLOTS) : 1;
	localparam int MAP_AW  = SLOT_W + VPN_W;
	localparam int RAM_AW  = FB + OFF;
	localparam int CLR_A   = (RAM_AW > MAP_AW) ? RAM_AW : MAP_AW;
	localparam int CLR_W   = (CLR_A > FB) ? CLR_A : FB;
	localparam int PG_W    = 22 - OFF;
	localparam int SUM_W   = ((AW > 22) ? AW : 22) + 1;
	localparam int FCW     = $clog2(FRAME_COUNT + 1);
	localparam logic [NEXT_W-1:0] CHAIN_END = '1;

	state_t state_q, state_d;

	// latched request
	kind_t             kind_q;
	logic [3:0]        pid_q;
	logic              pid_ok_q;
	logic [AW-1:0]     va_q;
	logic [7:0]        wd_q;
	logic [PG_W-1:0]   pages_q;

	// allocator and walker registers
	logic [AW-1:0]     brk_q [PROC_SLOTS];
	logic [FCW-1:0]    free_cnt_q;
	logic [FB:0]       scan_q;
	logic              chk_s1;
	logic [FB-1:0]     idx_s1;
	logic [PG_W-1:0]   taken_q;
	logic [FB-1:0]     prev_q;
	logic [VPN_W-1:0]  vpn_base_q;
	logic [FB-1:0]     cur_q;
	logic [FB:0]       step_q;
	logic [VPN_W-1:0]  vp_q;
	logic              vp_over_q;
	logic [CLR_W-1:0]  clr_q;

	// result registers
	logic              st_q;
	logic [AW-1:0]     base_q;
	logic [7:0]        rd_q;
	logic              out_valid_q;
	rsp_t              out_q;

	// memory ports
	logic              fm_we, fm_re;
	logic [FB-1:0]     fm_waddr, fm_raddr;
	logic [FM_W-1:0]   fm_wdata, fm_rdata;
	logic              pm_we;
	logic [MAP_AW-1:0] pm_waddr, pm_raddr;
	logic [PM_W-1:0]   pm_wdata, pm_rdata;
	logic              bm_we;
	logic [RAM_AW-1:0] bm_waddr, bm_raddr;
	logic [7:0]        bm_wdata, bm_rdata;

	// request decode
	logic              accept;
	logic [AW-1:0]     va_in;
	logic [SLOT_W-1:0] slot_in, slot;
	logic [21:0]       size_up;
	logic              pid_ok_in;

	assign accept    = req_valid && !req_stall;
	assign va_in     = AW'(req.vaddr);
	assign slot_in   = SLOT_W'(req.pid - 4'd1);
	assign slot      = SLOT_W'(pid_q - 4'd1);
	assign size_up   = 22'(req.req_size) + 22'((1 << OFF) - 1);
	assign pid_ok_in = (req.pid != 4'd0) && (32'(req.pid) <= 32'(PROC_SLOTS));

	// allocate check
	logic [AW-1:0]    bp;
	logic [SUM_W-1:0] brk_end;
	logic             alloc_ok;

	assign bp       = brk_q[slot];
	assign brk_end  = SUM_W'(bp) + (SUM_W'(pages_q) << OFF);
	assign alloc_ok = pid_ok_q && (32'(free_cnt_q) >= 32'(pages_q))
		&& ((brk_end >> AW) == '0);

	// frame table read fields
	logic [3:0]        owner_r;
	logic [NEXT_W-1:0] next_r;
	logic              hit, last_take, walk_stop;
	logic              pm_hit_ok;
	logic [FB-1:0]     pm_frame;

	assign owner_r   = fm_rdata[FM_W-1:NEXT_W];
	assign next_r    = fm_rdata[NEXT_W-1:0];
	assign pm_frame  = pm_rdata[FB-1:0];
	assign pm_hit_ok = pid_ok_q && pm_rdata[PM_W-1]
		&& (32'(pm_frame) < 32'(FRAME_COUNT));
	assign hit       = chk_s1 && (owner_r == 4'd0);
	assign last_take = hit && (PG_W'(taken_q + 1'b1) == pages_q);
	assign walk_stop = (step_q == (FB+1)'(FRAME_COUNT - 1))
		|| (32'(next_r) >= 32'(FRAME_COUNT));

	pmm_ram #(.WIDTH(FM_W), .ADDR_W(FB)) u_frame_ram (
		.clk(clk), .we(fm_we), .waddr(fm_waddr), .wdata(fm_wdata),
		.raddr(fm_raddr), .rdata(fm_rdata)
	);
	pmm_ram #(.WIDTH(PM_W), .ADDR_W(MAP_AW)) u_page_ram (
		.clk(clk), .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
		.raddr(pm_raddr), .rdata(pm_rdata)
	);
	pmm_ram #(.WIDTH(8), .ADDR_W(RAM_AW)) u_byte_ram (
		.clk(clk), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
		.raddr(bm_raddr), .rdata(bm_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory port control
	always_comb begin
		state_d  = state_q;
		fm_we    = 1'b0;
		fm_re    = 1'b0;
		fm_waddr = prev_q;
		fm_wdata = '0;
		fm_raddr = scan_q[FB-1:0];
		pm_we    = 1'b0;
		pm_waddr = {slot, vp_q};
		pm_wdata = '0;
		pm_raddr = {slot_in, va_in[AW-1:OFF]};
		bm_we    = 1'b0;
		bm_waddr = {pm_frame, va_q[OFF-1:0]};
		bm_wdata = wd_q;
		bm_raddr = {pm_frame, va_q[OFF-1:0]};
		case (state_q)
			ST_CLEAR: begin
				// sweep zeroes into every memory
				fm_we    = 1'b1;
				fm_waddr = clr_q[FB-1:0];
				pm_we    = 1'b1;
				pm_waddr = clr_q[MAP_AW-1:0];
				bm_we    = 1'b1;
				bm_waddr = clr_q[RAM_AW-1:0];
				bm_wdata = '0;
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					case (kind_t'(req.kind))
						KIND_ALLOC: state_d = ST_A_CHK;
						KIND_FREE:  state_d = ST_F_LOOK;
						default:    state_d = ST_RW_LOOK;
					endcase
				end
			end
			ST_A_CHK: begin
				if (!alloc_ok || pages_q == '0) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_A_SCAN;
				end
			end
			ST_A_SCAN: begin
				fm_re    = 1'b1;
				fm_raddr = scan_q[FB-1:0];
				if (hit) begin
					// map the next virtual page, link the previous frame here
					pm_we    = 1'b1;
					pm_waddr = {slot, VPN_W'(vpn_base_q + VPN_W'(taken_q))};
					pm_wdata = {1'b1, idx_s1};
					if (taken_q != '0) begin
						fm_we    = 1'b1;
						fm_waddr = prev_q;
						fm_wdata = {pid_q, NEXT_W'(idx_s1)};
					end
				end
				if (last_take) begin
					state_d = ST_A_END;
				end
			end
			ST_A_END: begin
				fm_we    = 1'b1;
				fm_waddr = prev_q;
				fm_wdata = {pid_q, CHAIN_END};
				state_d  = ST_DONE;
			end
			ST_F_LOOK: begin
				if (pm_hit_ok) begin
					fm_re    = 1'b1;
					fm_raddr = pm_frame;
					state_d  = ST_F_WALK;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_F_WALK: begin
				// release the frame, keep its link for later walks
				fm_we    = 1'b1;
				fm_waddr = cur_q;
				fm_wdata = {4'd0, next_r};
				if (!vp_over_q) begin
					pm_we = 1'b1;
				end
				if (walk_stop) begin
					state_d = ST_DONE;
				end else begin
					fm_re    = 1'b1;
					fm_raddr = next_r[FB-1:0];
				end
			end
			ST_RW_LOOK: begin
				if (!pm_hit_ok) begin
					state_d = ST_DONE;
				end else if (kind_q == KIND_WRITE) begin
					bm_we   = 1'b1;
					state_d = ST_DONE;
				end else begin
					state_d = ST_RW_DATA;
				end
			end
			ST_RW_DATA: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || !rsp_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign req_stall = (state_q != ST_IDLE);

	// control counters and break pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			free_cnt_q <= FCW'(FRAME_COUNT);
			chk_s1     <= 1'b0;
			for (int i = 0; i < PROC_SLOTS; i++) begin
				brk_q[i] <= AW'(1 << OFF);
			end
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
				end
				ST_A_CHK: begin
					chk_s1 <= 1'b0;
					if (alloc_ok && pages_q != '0) begin
						brk_q[slot] <= AW'(brk_end);
						free_cnt_q  <= free_cnt_q - FCW'(pages_q);
					end
				end
				ST_A_SCAN: begin
					chk_s1 <= (32'(scan_q) < 32'(FRAME_COUNT)) && !last_take;
				end
				ST_F_WALK: begin
					if (owner_r != 4'd0) begin
						free_cnt_q <= free_cnt_q + 1'b1;
					end
				end
				default: begin
					chk_s1 <= 1'b0;
				end
			endcase
		end
	end

	// request fields, walk pointers and results
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					kind_q   <= kind_t'(req.kind);
					pid_q    <= req.pid;
					pid_ok_q <= pid_ok_in;
					va_q     <= va_in;
					wd_q     <= req.write_data;
					pages_q  <= PG_W'(size_up >> OFF);
					st_q     <= 1'b0;
					base_q   <= '0;
					rd_q     <= '0;
				end
			end
			ST_A_CHK: begin
				scan_q     <= '0;
				taken_q    <= '0;
				vpn_base_q <= bp[AW-1:OFF];
				if (alloc_ok) begin
					base_q <= bp;
				end else begin
					st_q <= 1'b1;
				end
			end
			ST_A_SCAN: begin
				scan_q <= scan_q + 1'b1;
				idx_s1 <= scan_q[FB-1:0];
				if (hit) begin
					prev_q  <= idx_s1;
					taken_q <= taken_q + 1'b1;
				end
			end
			ST_F_LOOK: begin
				cur_q     <= pm_frame;
				step_q    <= '0;
				vp_q      <= va_q[AW-1:OFF];
				vp_over_q <= 1'b0;
			end
			ST_F_WALK: begin
				cur_q     <= next_r[FB-1:0];
				step_q    <= step_q + 1'b1;
				vp_q      <= vp_q + 1'b1;
				vp_over_q <= vp_over_q || (vp_q == '1);
			end
			ST_RW_LOOK: begin
				if (!pm_hit_ok) begin
					st_q <= 1'b1;
				end
			end
			ST_RW_DATA: begin
				rd_q <= bm_rdata;
			end
			default: begin
			end
		endcase
	end

	// output register, loaded from the done state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && (!out_valid_q || !rsp_stall)) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid_q || !rsp_stall)) begin
			out_q.status      <= st_q;
			out_q.region_base <= 20'(base_q);
			out_q.read_data   <= rd_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// frame table never reads the entry it writes in the same cycle
	`PMM_ASSERT_IMPLY(a_fm_no_overlap, fm_we && fm_re, fm_waddr != fm_raddr)
	// free frame count stays within the table
	`PMM_ASSERT_ALWAYS(a_free_cnt_range, 32'(free_cnt_q) <= 32'(FRAME_COUNT))
	// scan never claims more frames than requested
	`PMM_ASSERT_IMPLY(a_scan_bound, state_q == ST_A_SCAN, taken_q < pages_q)
	// a result leaves the done state only into an empty or draining output slot
	`PMM_ASSERT_IMPLY(a_done_load, state_q == ST_DONE && state_d == ST_IDLE,
		!out_valid_q || !rsp_stall)
endmodule
